### rtl/tse_pkg.sv
package tse_pkg;

  // Width of the frame byte counter; frames longer than 2**PosBits - 1 bytes are cut off.
  localparam int unsigned PosBits = 16;
  localparam logic [PosBits-1:0] PosMax = '1;

  // Wide enough for a position plus one plus a 16-bit length without overflow.
  localparam int unsigned SumBits = 18;

  localparam logic [PosBits-1:0] IpHeaderPos   = PosBits'(14);
  localparam logic [3:0]         HdrLenMin     = 4'd5;
  localparam logic [15:0]        TcpPreBytes   = 16'd12;
  localparam logic [15:0]        TcpOffBytes   = 16'd13;
  localparam logic [7:0]         RecTypeHshake = 8'h16;
  localparam logic [15:0]        RecSkipBytes  = 16'd4;
  localparam logic [7:0]         HsTypeCliHelo = 8'h01;
  localparam logic [15:0]        HsSkipBytes   = 16'd37;
  localparam logic [15:0]        ExtServerName = 16'h0000;

  typedef enum logic [4:0] {
    PH_IDLE       = 5'd0,
    PH_ETH        = 5'd1,
    PH_IP_SKIP    = 5'd2,
    PH_TCP_PRE    = 5'd3,
    PH_TCP_OFF    = 5'd4,
    PH_TCP_SKIP   = 5'd5,
    PH_REC_TYPE   = 5'd6,
    PH_REC_SKIP   = 5'd7,
    PH_HS_TYPE    = 5'd8,
    PH_HS_SKIP    = 5'd9,
    PH_SID_LEN    = 5'd10,
    PH_SID_SKIP   = 5'd11,
    PH_CS_HI      = 5'd12,
    PH_CS_LO      = 5'd13,
    PH_CS_SKIP    = 5'd14,
    PH_CM_LEN     = 5'd15,
    PH_CM_SKIP    = 5'd16,
    PH_EXTS_HI    = 5'd17,
    PH_EXTS_LO    = 5'd18,
    PH_EXT_T_HI   = 5'd19,
    PH_EXT_T_LO   = 5'd20,
    PH_EXT_L_HI   = 5'd21,
    PH_EXT_L_LO   = 5'd22,
    PH_SNI_L_HI   = 5'd23,
    PH_SNI_L_LO   = 5'd24,
    PH_EXT_SKIP   = 5'd25,
    PH_SN_LIST_HI = 5'd26,
    PH_SN_LIST_LO = 5'd27,
    PH_SN_TYPE    = 5'd28,
    PH_SN_LEN_HI  = 5'd29,
    PH_SN_LEN_LO  = 5'd30,
    PH_SN_NAME    = 5'd31
  } phase_e;

  typedef struct packed {
    logic        truncated;
    logic        name_last;
    logic [15:0] name_index;
    logic [7:0]  name_byte;
  } name_res_t;

endpackage

### rtl/tse_parser.sv
module tse_parser import tse_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic      in_last_i,
  input  logic      buf_space_i,
  output logic      res_push_o,
  output name_res_t res_o
);

  logic               in_vld_q, in_vld_d;
  logic [7:0]         in_byte_q;
  logic               in_last_q;
  logic               proc;

  phase_e             ph_q, ph_d, ph_cur;
  logic [PosBits-1:0] pos_q, pos_d;
  logic [15:0]        skip_q, skip_d;
  logic [PosBits-1:0] ext_end_q, ext_end_d;
  logic [15:0]        ext_rem_q, ext_rem_d;
  logic [15:0]        name_rem_q, name_rem_d;
  logic [7:0]         len_hi_q, len_hi_d;
  logic [15:0]        name_pos_q, name_pos_d;

  logic [15:0]        word;
  logic [15:0]        skip_dec, ext_dec, name_dec;
  logic [SumBits-1:0] ext_sum;
  logic               emit;

  // The input register is freed whenever the output buffer has room for a result.
  assign proc       = in_vld_q && buf_space_i;
  assign in_ready_o = !in_vld_q || proc;
  assign in_vld_d   = (in_valid_i && in_ready_o) ? 1'b1 : (proc ? 1'b0 : in_vld_q);

  assign word     = {len_hi_q, in_byte_q};
  assign skip_dec = skip_q - 16'd1;
  assign ext_dec  = ext_rem_q - 16'd1;
  assign name_dec = name_rem_q - 16'd1;
  assign ext_sum  = SumBits'(pos_q) + SumBits'(1) + SumBits'(word);
  assign ph_cur   = (pos_q == PosMax) ? PH_IDLE : ph_q;

  always_comb begin
    ph_d       = ph_cur;
    pos_d      = (pos_q == PosMax) ? pos_q : pos_q + PosBits'(1);
    skip_d     = skip_q;
    ext_end_d  = ext_end_q;
    ext_rem_d  = ext_rem_q;
    name_rem_d = name_rem_q;
    len_hi_d   = len_hi_q;
    name_pos_d = name_pos_q;

    case (ph_cur)
      PH_ETH: begin
        if (pos_q == IpHeaderPos) begin
          if (in_byte_q[3:0] < HdrLenMin) begin
            ph_d = PH_IDLE;
          end else begin
            skip_d = 16'({in_byte_q[3:0], 2'b00}) - 16'd1;
            ph_d   = PH_IP_SKIP;
          end
        end
      end
      PH_IP_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == 16'd0) begin
          skip_d = TcpPreBytes;
          ph_d   = PH_TCP_PRE;
        end
      end
      PH_TCP_PRE: begin
        skip_d = skip_dec;
        if (skip_dec == 16'd0) ph_d = PH_TCP_OFF;
      end
      PH_TCP_OFF: begin
        if (in_byte_q[7:4] < HdrLenMin) begin
          ph_d = PH_IDLE;
        end else begin
          skip_d = 16'({in_byte_q[7:4], 2'b00}) - TcpOffBytes;
          ph_d   = PH_TCP_SKIP;
        end
      end
      PH_TCP_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == 16'd0) ph_d = PH_REC_TYPE;
      end
      PH_REC_TYPE: begin
        if (in_byte_q == RecTypeHshake) begin
          skip_d = RecSkipBytes;
          ph_d   = PH_REC_SKIP;
        end else begin
          ph_d = PH_IDLE;
        end
      end
      PH_REC_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == 16'd0) ph_d = PH_HS_TYPE;
      end
      PH_HS_TYPE: begin
        if (in_byte_q == HsTypeCliHelo) begin
          skip_d = HsSkipBytes;
          ph_d   = PH_HS_SKIP;
        end else begin
          ph_d = PH_IDLE;
        end
      end
      PH_HS_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == 16'd0) ph_d = PH_SID_LEN;
      end
      PH_SID_LEN: begin
        if (in_byte_q == 8'd0) begin
          ph_d = PH_CS_HI;
        end else begin
          skip_d = 16'(in_byte_q);
          ph_d   = PH_SID_SKIP;
        end
      end
      PH_SID_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == 16'd0) ph_d = PH_CS_HI;
      end
      PH_CS_HI: begin
        len_hi_d = in_byte_q;
        ph_d     = PH_CS_LO;
      end
      PH_CS_LO: begin
        if (word == 16'd0) begin
          ph_d = PH_CM_LEN;
        end else begin
          skip_d = word;
          ph_d   = PH_CS_SKIP;
        end
      end
      PH_CS_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == 16'd0) ph_d = PH_CM_LEN;
      end
      PH_CM_LEN: begin
        if (in_byte_q == 8'd0) begin
          ph_d = PH_EXTS_HI;
        end else begin
          skip_d = 16'(in_byte_q);
          ph_d   = PH_CM_SKIP;
        end
      end
      PH_CM_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == 16'd0) ph_d = PH_EXTS_HI;
      end
      PH_EXTS_HI: begin
        len_hi_d = in_byte_q;
        ph_d     = PH_EXTS_LO;
      end
      PH_EXTS_LO: begin
        // The end position saturates so that a huge length cannot wrap around.
        if (ext_sum > SumBits'(PosMax)) begin
          ext_end_d = PosMax;
        end else begin
          ext_end_d = ext_sum[PosBits-1:0];
        end
        ph_d = PH_EXT_T_HI;
      end
      PH_EXT_T_HI: begin
        if (pos_q >= ext_end_q) begin
          ph_d = PH_IDLE;
        end else begin
          len_hi_d = in_byte_q;
          ph_d     = PH_EXT_T_LO;
        end
      end
      PH_EXT_T_LO: begin
        ph_d = (word == ExtServerName) ? PH_SNI_L_HI : PH_EXT_L_HI;
      end
      PH_EXT_L_HI: begin
        len_hi_d = in_byte_q;
        ph_d     = PH_EXT_L_LO;
      end
      PH_EXT_L_LO: begin
        ext_rem_d = word;
        ph_d      = (word == 16'd0) ? PH_EXT_T_HI : PH_EXT_SKIP;
      end
      PH_SNI_L_HI: begin
        len_hi_d = in_byte_q;
        ph_d     = PH_SNI_L_LO;
      end
      PH_SNI_L_LO: begin
        ext_rem_d = word;
        ph_d      = (word == 16'd0) ? PH_EXT_T_HI : PH_SN_LIST_HI;
      end
      PH_EXT_SKIP: begin
        ext_rem_d = ext_dec;
        if (ext_dec == 16'd0) ph_d = PH_EXT_T_HI;
      end
      PH_SN_LIST_HI: begin
        ext_rem_d = ext_dec;
        ph_d      = (ext_dec == 16'd0) ? PH_EXT_T_HI : PH_SN_LIST_LO;
      end
      PH_SN_LIST_LO: begin
        ext_rem_d = ext_dec;
        ph_d      = (ext_dec == 16'd0) ? PH_EXT_T_HI : PH_SN_TYPE;
      end
      PH_SN_TYPE: begin
        ext_rem_d = ext_dec;
        ph_d      = (ext_dec == 16'd0) ? PH_EXT_T_HI : PH_SN_LEN_HI;
      end
      PH_SN_LEN_HI: begin
        len_hi_d  = in_byte_q;
        ext_rem_d = ext_dec;
        ph_d      = (ext_dec == 16'd0) ? PH_EXT_T_HI : PH_SN_LEN_LO;
      end
      PH_SN_LEN_LO: begin
        name_rem_d = word;
        name_pos_d = 16'd0;
        ext_rem_d  = ext_dec;
        if (ext_dec == 16'd0) begin
          ph_d = PH_EXT_T_HI;
        end else begin
          ph_d = (word == 16'd0) ? PH_EXT_SKIP : PH_SN_NAME;
        end
      end
      PH_SN_NAME: begin
        name_rem_d = name_dec;
        ext_rem_d  = ext_dec;
        name_pos_d = name_pos_q + 16'd1;
        if (ext_dec == 16'd0) begin
          ph_d = PH_EXT_T_HI;
        end else if (name_dec == 16'd0) begin
          ph_d = PH_EXT_SKIP;
        end
      end
      default: begin
      end
    endcase

    if (in_last_q) begin
      ph_d  = PH_ETH;
      pos_d = '0;
    end
  end

  always_comb begin
    logic finished;
    finished          = (name_dec == 16'd0) || (ext_dec == 16'd0);
    emit              = (ph_cur == PH_SN_NAME);
    res_o.name_byte   = in_byte_q;
    res_o.name_index  = name_pos_q;
    res_o.name_last   = finished || in_last_q;
    res_o.truncated   = in_last_q && !finished;
    res_push_o        = proc && emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      ph_q       <= PH_ETH;
      pos_q      <= '0;
      skip_q     <= '0;
      ext_end_q  <= '0;
      ext_rem_q  <= '0;
      name_rem_q <= '0;
      len_hi_q   <= '0;
      name_pos_q <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      if (proc) begin
        ph_q       <= ph_d;
        pos_q      <= pos_d;
        skip_q     <= skip_d;
        ext_end_q  <= ext_end_d;
        ext_rem_q  <= ext_rem_d;
        name_rem_q <= name_rem_d;
        len_hi_q   <= len_hi_d;
        name_pos_q <= name_pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

endmodule

### rtl/tse_out_buf.sv
module tse_out_buf import tse_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  name_res_t res_i,
  output logic      space_o,
  output logic      valid_o,
  input  logic      ready_i,
  output name_res_t res_o
);

  name_res_t   slot_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q, cnt_d;
  logic        pop;

  // Two slots let the parser keep running while the sink stalls, until both are full.
  assign space_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign res_o   = slot_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= res_i;
  end

endmodule

### rtl/tls_sni_extractor_top.sv
// Channel  | Direction | tdata                                  | tlast      | tuser
// s_axis   | in        | [7:0] frame_byte                       | frame_last | -
// m_axis   | out       | [7:0] name_byte, [23:8] name_index     | name_last  | truncated
//
// One frame byte is accepted per cycle while the output buffer has room. Each byte is
// parsed from the input register, and a name byte is offered on m_axis from the buffer.
// The parser state is updated combinationally between the input register and a
// two-entry output buffer. Reset clears the parser to the start of a frame.
// When the sink stalls, the output buffer fills, then the input register holds and
// s_axis_tready_o drops; s_axis_tready_o depends on registers only.
module tls_sni_extractor_top import tse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] frame_byte
  input  logic        s_axis_tlast_i,   // frame_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] name_byte, [23:8] name_index
  output logic        m_axis_tlast_o,   // name_last
  output logic        m_axis_tuser_o    // truncated
);

  logic      buf_space;
  logic      res_push;
  name_res_t res_new, res_out;

  tse_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_byte_i   (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .buf_space_i (buf_space),
    .res_push_o  (res_push),
    .res_o       (res_new)
  );

  tse_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res_new),
    .space_o (buf_space),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (res_out)
  );

  assign m_axis_tdata_o = {res_out.name_index, res_out.name_byte};
  assign m_axis_tlast_o = res_out.name_last;
  assign m_axis_tuser_o = res_out.truncated;

endmodule
